// ===== hdl/lru_key_value_cache_core_defines.svh =====
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define KVC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kvc port check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define KVC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kvc port check failed");

`endif

// ===== hdl/kvc_pkg.sv =====
package kvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 32;
    localparam int STORE_VW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int MEM_W    = KEY_W + STORE_VW;
    localparam int CAP_W    = 5;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam int S_TDATA_W = KEY_W + VAL_W;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = VAL_W + KEY_W;
    localparam int M_TUSER_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_NEW     = 2'd0;
    localparam t_status ST_UPDATED = 2'd1;
    localparam t_status ST_HIT     = 2'd2;
    localparam t_status ST_MISS    = 2'd3;

    typedef logic [1:0] t_op;
    localparam t_op OP_NONE   = 2'd0;
    localparam t_op OP_TOUCH  = 2'd1;
    localparam t_op OP_INSERT = 2'd2;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic             evict;
        logic [IDX_W-1:0] victim;
    } t_lru_cmd;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] rank;
        logic [CNT_W-1:0] count;
    } t_lru_view;

    function automatic logic [CMP_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] c;
        c = CMP_W'(cap);
        if (c == '0) begin
            c = CMP_W'(1);
        end
        if (c > CMP_W'(ENTRIES)) begin
            c = CMP_W'(ENTRIES);
        end
        return c;
    endfunction

endpackage

// ===== hdl/kvc_ram.sv =====
module kvc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/kvc_lru.sv =====
module kvc_lru (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [kvc_pkg::IDX_W-1:0]        i_rd_idx,
    output kvc_pkg::t_lru_view               o_view,
    input  kvc_pkg::t_lru_cmd                i_cmd
);

    logic [kvc_pkg::ENTRIES-1:0]                     r_valid, n_valid;
    logic [kvc_pkg::ENTRIES-1:0][kvc_pkg::IDX_W-1:0] r_rank, n_rank;
    logic [kvc_pkg::CNT_W-1:0]                       r_count, n_count;
    logic [kvc_pkg::IDX_W-1:0]                       touch_rank;

    always_comb begin
        o_view.valid = r_valid[i_rd_idx];
        o_view.rank  = r_rank[i_rd_idx];
        o_view.count = r_count;
    end

    always_comb begin
        logic keep;
        n_valid    = r_valid;
        n_rank     = r_rank;
        n_count    = r_count;
        touch_rank = r_rank[i_cmd.idx];
        keep       = 1'b0;
        unique case (i_cmd.op)
            kvc_pkg::OP_TOUCH: begin
                for (int i = 0; i < kvc_pkg::ENTRIES; i++) begin
                    if (r_valid[i] && kvc_pkg::IDX_W'(i) != i_cmd.idx
                        && r_rank[i] < touch_rank) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
                n_rank[i_cmd.idx] = '0;
            end
            kvc_pkg::OP_INSERT: begin
                for (int i = 0; i < kvc_pkg::ENTRIES; i++) begin
                    keep = r_valid[i] && !(i_cmd.evict && i_cmd.victim == kvc_pkg::IDX_W'(i));
                    if (kvc_pkg::IDX_W'(i) == i_cmd.idx) begin
                        n_valid[i] = 1'b1;
                        n_rank[i]  = '0;
                    end else begin
                        n_valid[i] = keep;
                        if (keep) begin
                            n_rank[i] = r_rank[i] + 1'b1;
                        end
                    end
                end
                if (!i_cmd.evict) begin
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rank  <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
            r_count <= n_count;
        end
    end

endmodule

// ===== hdl/kvc_ctrl.sv =====
module kvc_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [kvc_pkg::CAP_W-1:0]          i_capacity,
    input  logic                               i_s_valid,
    output logic                               o_s_ready,
    input  logic                               i_mode,
    input  logic [kvc_pkg::KEY_W-1:0]          i_key,
    input  logic [kvc_pkg::VAL_W-1:0]          i_value,
    output logic                               o_m_valid,
    input  logic                               i_m_ready,
    output kvc_pkg::t_status                   o_status,
    output logic [kvc_pkg::VAL_W-1:0]          o_value_res,
    output logic                               o_evicted,
    output logic [kvc_pkg::KEY_W-1:0]          o_evicted_key,
    output logic                               o_ram_we,
    output logic [kvc_pkg::IDX_W-1:0]          o_ram_waddr,
    output logic [kvc_pkg::MEM_W-1:0]          o_ram_wdata,
    output logic                               o_ram_re,
    output logic [kvc_pkg::IDX_W-1:0]          o_ram_raddr,
    input  logic [kvc_pkg::MEM_W-1:0]          i_ram_rdata,
    output logic [kvc_pkg::IDX_W-1:0]          o_lru_rd_idx,
    input  kvc_pkg::t_lru_view                 i_lru_view,
    output kvc_pkg::t_lru_cmd                  o_lru_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [kvc_pkg::IDX_W-1:0]     r_addr;
    logic                          r_rd_vld;
    logic [kvc_pkg::IDX_W-1:0]     r_rd_idx;
    logic                          r_mode;
    logic [kvc_pkg::KEY_W-1:0]     r_key;
    logic [kvc_pkg::STORE_VW-1:0]  r_val;
    logic                          r_hit;
    logic [kvc_pkg::IDX_W-1:0]     r_hit_idx;
    logic [kvc_pkg::STORE_VW-1:0]  r_hit_val;
    logic                          r_free_found;
    logic [kvc_pkg::IDX_W-1:0]     r_free_idx;
    logic [kvc_pkg::IDX_W-1:0]     r_vic_idx;
    logic [kvc_pkg::KEY_W-1:0]     r_vic_key;
    logic                          r_out_valid;
    kvc_pkg::t_status              r_out_status;
    logic [kvc_pkg::VAL_W-1:0]     r_out_value;
    logic                          r_out_evicted;
    logic [kvc_pkg::KEY_W-1:0]     r_out_evkey;

    logic                          s_fire;
    logic [kvc_pkg::KEY_W-1:0]     rd_key;
    logic [kvc_pkg::STORE_VW-1:0]  rd_val;
    logic                          is_match;
    logic                          is_free;
    logic                          is_victim;
    logic                          do_evict;
    logic                          out_free;
    logic                          commit;
    logic [kvc_pkg::IDX_W-1:0]     slot;
    logic                          is_insert;
    kvc_pkg::t_status              res_status;
    logic [kvc_pkg::VAL_W-1:0]     res_value;
    logic                          res_evicted;
    logic [kvc_pkg::KEY_W-1:0]     res_evkey;

    assign o_s_ready = (r_state == S_IDLE);
    assign s_fire    = i_s_valid && o_s_ready;

    assign o_ram_re     = (r_state == S_SCAN);
    assign o_ram_raddr  = r_addr;
    assign o_lru_rd_idx = r_rd_idx;

    assign rd_key = i_ram_rdata[kvc_pkg::KEY_W-1:0];
    assign rd_val = i_ram_rdata[kvc_pkg::MEM_W-1:kvc_pkg::KEY_W];

    assign is_match  = r_rd_vld && i_lru_view.valid && (rd_key == r_key);
    assign is_free   = r_rd_vld && !i_lru_view.valid;
    assign is_victim = r_rd_vld && i_lru_view.valid
                       && (kvc_pkg::CNT_W'(i_lru_view.rank)
                           == i_lru_view.count - kvc_pkg::CNT_W'(1));

    assign do_evict  = kvc_pkg::CMP_W'(i_lru_view.count) >= kvc_pkg::eff_capacity(i_capacity);
    assign out_free  = !r_out_valid || i_m_ready;
    assign commit    = (r_state == S_COMMIT) && out_free;
    assign is_insert = (r_mode == kvc_pkg::MODE_INSERT);

    always_comb begin
        if (do_evict && (!r_free_found || r_vic_idx < r_free_idx)) begin
            slot = r_vic_idx;
        end else begin
            slot = r_free_idx;
        end
    end

    always_comb begin
        o_lru_cmd.op     = kvc_pkg::OP_NONE;
        o_lru_cmd.idx    = slot;
        o_lru_cmd.evict  = do_evict;
        o_lru_cmd.victim = r_vic_idx;
        if (commit) begin
            if (r_hit) begin
                o_lru_cmd.op  = kvc_pkg::OP_TOUCH;
                o_lru_cmd.idx = r_hit_idx;
            end else if (is_insert) begin
                o_lru_cmd.op  = kvc_pkg::OP_INSERT;
            end
        end
    end

    assign o_ram_we    = commit && is_insert;
    assign o_ram_waddr = r_hit ? r_hit_idx : slot;
    assign o_ram_wdata = {r_val, r_key};

    always_comb begin
        res_value   = '0;
        res_evicted = 1'b0;
        res_evkey   = '0;
        if (!is_insert) begin
            res_status = r_hit ? kvc_pkg::ST_HIT : kvc_pkg::ST_MISS;
            if (r_hit) begin
                res_value = kvc_pkg::VAL_W'(r_hit_val);
            end
        end else begin
            res_status = r_hit ? kvc_pkg::ST_UPDATED : kvc_pkg::ST_NEW;
            if (!r_hit && do_evict) begin
                res_evicted = 1'b1;
                res_evkey   = r_vic_key;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (s_fire) n_state = S_SCAN;
            S_SCAN:   if (r_addr == kvc_pkg::IDX_W'(kvc_pkg::ENTRIES - 1)) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_COMMIT;
            S_COMMIT: if (out_free) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            if (s_fire) begin
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (is_match) begin
                    r_hit <= 1'b1;
                end
                if (is_free) begin
                    r_free_found <= 1'b1;
                end
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (s_fire) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_val  <= i_value[kvc_pkg::STORE_VW-1:0];
            r_addr <= '0;
        end else if (r_state == S_SCAN) begin
            r_addr <= r_addr + 1'b1;
        end
        if (is_match) begin
            r_hit_idx <= r_rd_idx;
            r_hit_val <= rd_val;
        end
        if (is_free && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        if (is_victim) begin
            r_vic_idx <= r_rd_idx;
            r_vic_key <= rd_key;
        end
        if (commit) begin
            r_out_status  <= res_status;
            r_out_value   <= res_value;
            r_out_evicted <= res_evicted;
            r_out_evkey   <= res_evkey;
        end
    end

    assign o_m_valid     = r_out_valid;
    assign o_status      = r_out_status;
    assign o_value_res   = r_out_value;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_evkey;

endmodule

// ===== hdl/lru_key_value_cache_core.sv =====
// Fully associative 16-entry key/value cache with least-recently-used replacement. Each
// input transfer is an insert (tuser 0) or a lookup (tuser 1) of a 64-bit key, and gives
// exactly one result transfer. Keys and values sit in a single-port-read synchronous memory
// that is scanned one entry per cycle, while valid bits, recency ranks and the fill count sit
// in flip-flops that reset clears at once, so there is no clearing pass after reset. One item
// is in work at a time: each input transfer starts a scan that reads all 16 memory entries,
// a drain state waits for the last read, and a commit state writes the item back and
// registers its result; the next item is taken once the block is back in idle, so the
// block does not take a new item before it is through with the last. The writeback of an
// item lands before the next item's scan begins. A result waiting in the output register
// does not block the next item's scan, only its writeback. Capacity is written over the
// cfg channel, always ready; the user must write it only while the block is idle, as the
// block itself does not enforce this; zero acts as one and values above 16 act as 16.
module lru_key_value_cache_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [kvc_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // key, value
    input  logic [kvc_pkg::S_TUSER_W-1:0]     s_axis_tuser,   // mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [kvc_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // value_res, evicted_key
    output logic [kvc_pkg::M_TUSER_W-1:0]     m_axis_tuser,   // status, evicted
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kvc_pkg::CAP_W-1:0]         i_cfg_data      // capacity
);

    logic [kvc_pkg::CAP_W-1:0]  r_capacity;

    logic                       ram_we;
    logic [kvc_pkg::IDX_W-1:0]  ram_waddr;
    logic [kvc_pkg::MEM_W-1:0]  ram_wdata;
    logic                       ram_re;
    logic [kvc_pkg::IDX_W-1:0]  ram_raddr;
    logic [kvc_pkg::MEM_W-1:0]  ram_rdata;

    logic [kvc_pkg::IDX_W-1:0]  lru_rd_idx;
    kvc_pkg::t_lru_view         lru_view;
    kvc_pkg::t_lru_cmd          lru_cmd;

    kvc_pkg::t_status           status;
    logic [kvc_pkg::VAL_W-1:0]  value_res;
    logic                       evicted;
    logic [kvc_pkg::KEY_W-1:0]  evicted_key;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= kvc_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    kvc_ram #(
        .DEPTH (kvc_pkg::ENTRIES),
        .WIDTH (kvc_pkg::MEM_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    kvc_lru u_lru (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (lru_rd_idx),
        .o_view   (lru_view),
        .i_cmd    (lru_cmd)
    );

    kvc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_capacity    (r_capacity),
        .i_s_valid     (s_axis_tvalid),
        .o_s_ready     (s_axis_tready),
        .i_mode        (s_axis_tuser[0]),
        .i_key         (s_axis_tdata[kvc_pkg::KEY_W-1:0]),
        .i_value       (s_axis_tdata[kvc_pkg::S_TDATA_W-1:kvc_pkg::KEY_W]),
        .o_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .o_status      (status),
        .o_value_res   (value_res),
        .o_evicted     (evicted),
        .o_evicted_key (evicted_key),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_lru_rd_idx  (lru_rd_idx),
        .i_lru_view    (lru_view),
        .o_lru_cmd     (lru_cmd)
    );

    assign m_axis_tdata = {evicted_key, value_res};
    assign m_axis_tuser = {evicted, status};

endmodule

// ===== hdl/kvc_checker.sv =====
`include "lru_key_value_cache_core_defines.svh"

module kvc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [kvc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input logic [kvc_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    // only a new-key insert can push an entry out
    `KVC_ASSERT_IMP(a_evict_only_on_new, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == kvc_pkg::ST_NEW)

    // no eviction means a zero evicted key
    `KVC_ASSERT_IMP(a_evkey_zero, m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata[kvc_pkg::M_TDATA_W-1:kvc_pkg::VAL_W] == '0)

    // a value comes back only on a lookup hit
    `KVC_ASSERT_IMP(a_value_only_on_hit, m_axis_tvalid && m_axis_tuser[1:0] != kvc_pkg::ST_HIT, m_axis_tdata[kvc_pkg::VAL_W-1:0] == '0)

    // one item in work at a time
    `KVC_ASSERT_NXT(a_one_in_work, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a stalled result holds
    `KVC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind lru_key_value_cache_core kvc_checker u_kvc_checker (.*);
